// ===== hw/rtl/rc5_pkg.sv =====
// Shared constants, types and rotate helpers for the RC5-32 block cipher.
`default_nettype none

package rc5_pkg;

  localparam int unsigned ROUNDS_DEF = 16;
  localparam int unsigned WORD_W     = 32;

  localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic decrypt;
    logic whiten;
  } rnd_ctrl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t rotr(input word_t x, input logic [4:0] n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} >> n;
    return t[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rc5_round.sv =====
// One RC5 round or whitening step, either direction, on a pair of round keys.
`default_nettype none

module rc5_round (
  input  wire rc5_pkg::rnd_ctrl_t ctrl,
  input  wire rc5_pkg::word_t     a,
  input  wire rc5_pkg::word_t     b,
  input  wire rc5_pkg::word_t     k_even,
  input  wire rc5_pkg::word_t     k_odd,
  output rc5_pkg::word_t          a_new,
  output rc5_pkg::word_t          b_new
);

  rc5_pkg::word_t enc_a;
  rc5_pkg::word_t enc_b;
  rc5_pkg::word_t dec_a;
  rc5_pkg::word_t dec_b;

  always_comb begin
    enc_a = rc5_pkg::rotl(a ^ b, b[4:0]) + k_even;
    enc_b = rc5_pkg::rotl(b ^ enc_a, enc_a[4:0]) + k_odd;
    dec_b = rc5_pkg::rotr(b - k_odd, a[4:0]) ^ a;
    dec_a = rc5_pkg::rotr(a - k_even, dec_b[4:0]) ^ dec_b;
  end

  always_comb begin
    case ({ctrl.decrypt, ctrl.whiten})
      2'b01: begin
        a_new = a + k_even;
        b_new = b + k_odd;
      end
      2'b10: begin
        a_new = dec_a;
        b_new = dec_b;
      end
      2'b11: begin
        a_new = a - k_even;
        b_new = b - k_odd;
      end
      default: begin
        a_new = enc_a;
        b_new = enc_b;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rc5_block_cipher.sv =====
// Top level of the RC5-32 block cipher with key expansion into banked key memory.
//
//   port group   direction  handshake                 payload
//   req          in         req_valid / req_stall     kind, word_a, word_b
//   res          out        res_valid / res_stall     out_a, out_b
//   apb          in/out     psel, penable, pready     paddr, pwdata, prdata (cipher_key at 0)
//
// After reset or a key write the key expansion runs: a load step, the fill of the key banks,
// a prime step and the mixing steps, each a MIXA and a MIXB state; req_stall is high meanwhile.
// A request is run to its end before the next one is accepted: one round per cycle, paced by
// one read of the even/odd round key banks per cycle.
// A stalled result holds the block in a wait state until it is taken.
`default_nettype none

module rc5_block_cipher #(
  parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   req_valid,
  output logic                  req_stall,
  input  wire                   kind,
  input  wire  [31:0]           word_a,
  input  wire  [31:0]           word_b,
  output logic                  res_valid,
  input  wire                   res_stall,
  output logic [31:0]           out_a,
  output logic [31:0]           out_b,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [3:0]            paddr,
  input  wire  [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int unsigned NPAIRS    = ROUNDS + 1;
  localparam int unsigned NKEYS     = 2 * NPAIRS;
  localparam int unsigned MIX_STEPS = 3 * NKEYS;
  localparam int unsigned AW        = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;
  localparam int unsigned SIW       = AW + 1;
  localparam int unsigned MSW       = $clog2(MIX_STEPS);

  localparam logic [AW-1:0]  LAST_PAIR = AW'(ROUNDS);
  localparam logic [SIW-1:0] SI_LAST   = SIW'(NKEYS - 1);
  localparam logic [MSW-1:0] MIX_LAST  = MSW'(MIX_STEPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_PRIME = 3'd2;
  localparam logic [2:0] ST_MIXA  = 3'd3;
  localparam logic [2:0] ST_MIXB  = 3'd4;
  localparam logic [2:0] ST_RUN   = 3'd5;
  localparam logic [2:0] ST_WAIT  = 3'd6;

  localparam logic REG_KEY = 1'b0;

  logic [2:0]      state;
  logic            sched_done;
  logic            pending;
  logic [63:0]     cipher_key;

  rc5_pkg::word_t  lw0;
  rc5_pkg::word_t  lw1;
  rc5_pkg::word_t  ga;
  rc5_pkg::word_t  gb;
  rc5_pkg::word_t  acc;
  logic [SIW-1:0]  si;
  logic            ki;
  logic [MSW-1:0]  step;

  logic            kind_r;
  logic [AW-1:0]   j;
  rc5_pkg::word_t  a;
  rc5_pkg::word_t  b;

  rc5_pkg::word_t  mem_even [NPAIRS];
  rc5_pkg::word_t  mem_odd  [NPAIRS];
  rc5_pkg::word_t  rd_even;
  rc5_pkg::word_t  rd_odd;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_even;
  logic            wr_odd;
  logic [AW-1:0]   wr_addr;
  rc5_pkg::word_t  wr_data;

  logic            cfg_wr;
  logic            req_acc;
  logic            res_free;
  logic            last;
  logic [SIW-1:0]  si_wrap;
  logic [AW-1:0]   j_step;
  rc5_pkg::word_t  s_data;
  rc5_pkg::word_t  ga_new;
  rc5_pkg::word_t  gb_new;
  rc5_pkg::word_t  mix_sum;
  rc5_pkg::word_t  lw_sel;
  rc5_pkg::word_t  a_new;
  rc5_pkg::word_t  b_new;
  rc5_pkg::rnd_ctrl_t rnd_ctrl;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[3] == REG_KEY);
  assign prdata    = (paddr[3] == REG_KEY) ? cipher_key : 64'd0;
  assign req_stall = !((state == ST_IDLE) && sched_done);
  assign req_acc   = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  assign si_wrap = (si == SI_LAST) ? '0 : si + 1'b1;
  assign j_step  = kind_r ? j - 1'b1 : j + 1'b1;
  assign last    = kind_r ? (j == '0) : (j == LAST_PAIR);

  assign s_data  = si[0] ? rd_odd : rd_even;
  assign ga_new  = rc5_pkg::rotl(s_data + ga + gb, 5'd3);
  assign mix_sum = ga + gb;
  assign lw_sel  = ki ? lw1 : lw0;
  assign gb_new  = rc5_pkg::rotl(lw_sel + mix_sum, mix_sum[4:0]);

  assign rnd_ctrl.decrypt = kind_r;
  assign rnd_ctrl.whiten  = (j == '0);

  rc5_round u_round (
    .ctrl   (rnd_ctrl),
    .a      (a),
    .b      (b),
    .k_even (rd_even),
    .k_odd  (rd_odd),
    .a_new  (a_new),
    .b_new  (b_new)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          rd_en   = 1'b1;
          rd_addr = kind ? LAST_PAIR : '0;
        end
      end
      ST_PRIME: begin
        rd_en = 1'b1;
      end
      ST_MIXB: begin
        rd_en   = 1'b1;
        rd_addr = si_wrap[SIW-1:1];
      end
      ST_RUN: begin
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = j_step;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_addr = si[SIW-1:1];
  assign wr_data = (state == ST_FILL) ? acc : ga_new;
  assign wr_even = ((state == ST_FILL) || (state == ST_MIXA)) && !si[0];
  assign wr_odd  = ((state == ST_FILL) || (state == ST_MIXA)) && si[0];

  always_ff @(posedge clk) begin
    if (wr_even) begin
      mem_even[wr_addr] <= wr_data;
    end
    if (wr_odd) begin
      mem_odd[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_even <= mem_even[rd_addr];
      rd_odd  <= mem_odd[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sched_done <= 1'b0;
      pending    <= 1'b1;
      cipher_key <= 64'd0;
      res_valid  <= 1'b0;
    end else begin
      if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pending) begin
            pending    <= 1'b0;
            sched_done <= 1'b0;
            lw0        <= cipher_key[31:0];
            lw1        <= cipher_key[63:32];
            acc        <= rc5_pkg::MAGIC_P;
            si         <= '0;
            state      <= ST_FILL;
          end else if (req_acc) begin
            kind_r <= kind;
            a      <= word_a;
            b      <= word_b;
            j      <= kind ? LAST_PAIR : '0;
            state  <= ST_RUN;
          end
        end
        ST_FILL: begin
          acc <= acc + rc5_pkg::MAGIC_Q;
          if (si == SI_LAST) begin
            si    <= '0;
            state <= ST_PRIME;
          end else begin
            si <= si + 1'b1;
          end
        end
        ST_PRIME: begin
          ga    <= '0;
          gb    <= '0;
          ki    <= 1'b0;
          step  <= '0;
          state <= ST_MIXA;
        end
        ST_MIXA: begin
          ga    <= ga_new;
          state <= ST_MIXB;
        end
        ST_MIXB: begin
          gb <= gb_new;
          if (ki) begin
            lw1 <= gb_new;
          end else begin
            lw0 <= gb_new;
          end
          ki   <= !ki;
          si   <= si_wrap;
          step <= step + 1'b1;
          if (step == MIX_LAST) begin
            sched_done <= !pending;
            state      <= ST_IDLE;
          end else begin
            state <= ST_MIXA;
          end
        end
        ST_RUN: begin
          j <= j_step;
          if (last && res_free) begin
            out_a     <= a_new;
            out_b     <= b_new;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            a <= a_new;
            b <= b_new;
            if (last) begin
              state <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (res_free) begin
            out_a     <= a;
            out_b     <= b;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_wr) begin
        cipher_key <= pwdata;
        pending    <= 1'b1;
        sched_done <= 1'b0;
      end
    end
  end

  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_RUN || $past(state) == ST_WAIT))
    else $error("result raised outside the round datapath");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_WAIT) |-> !(wr_even || wr_odd))
    else $error("key memory written while a request is in flight");

  a_mix_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIXB && step == MIX_LAST) |=> (state == ST_IDLE))
    else $error("key expansion did not end after the last mixing step");

  a_one_bank: assert property (@(posedge clk) disable iff (rst)
    (wr_even || wr_odd) |-> !rd_en)
    else $error("key memory read and written in the same cycle");

endmodule

`default_nettype wire
